FILE: hw/rtl/assert_macros.svh
// Assertion helpers for the RTL; logical_line_end_detector.sv includes them.
// Each macro expands to one labeled concurrent assertion that is clocked on the
// rising edge and disabled while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge.
`define ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// The antecedent at one edge implies the consequent at the next edge.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// The antecedent implies the consequent at the same edge.
`define ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/lled_pkg.sv
package lled_pkg;

  // Character codes that the scanner reacts to.
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_BAR     = 8'h7C;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_TILDE   = 8'h7E;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_LBRACK  = 8'h5B;
  localparam logic [7:0] CH_RBRACK  = 8'h5D;
  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;

  // Folding mask (octal 0137): clears bits 7 and 5; bit 5 makes letters case-insensitive.
  localparam logic [7:0] FOLD_MASK = 8'h5F;

  // The END matcher has five steps: newline, E, N, D, newline.
  localparam logic [2:0] END_LEN  = 3'd5;
  localparam logic [2:0] END_LAST = 3'd4;

  // Configuration register indexes.
  localparam logic [7:0] CFG_CONTINUATION = 8'd0;
  localparam logic [7:0] CFG_END_CHECK    = 8'd1;

  // Why a line ended.
  typedef enum logic [1:0] {
    REASON_NONE    = 2'd0,
    REASON_NEWLINE = 2'd1,
    REASON_EOI     = 2'd2,
    REASON_END     = 2'd3
  } reason_t;

  // Configuration bits.
  typedef struct packed {
    logic continuation_enable;
    logic end_check_enable;
  } lled_cfg_t;

  // Per-line flags; the depth counters travel separately since their width
  // follows a parameter.
  typedef struct packed {
    logic       bar_quoted;
    logic       escape_pending;
    logic       tilde_skipping;
    logic [2:0] end_match_pos;
    logic       escape_seen;
  } lled_flags_t;

  // One result item.
  typedef struct packed {
    logic       keep_valid;
    logic [7:0] kept_char;
    logic       escaped;
    logic       line_done;
    reason_t    end_reason;
    logic       line_had_escape;
  } lled_result_t;

  // Expected folded character at each matcher step.
  function automatic logic [7:0] end_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = CH_NEWLINE;
      3'd1:    c = 8'h45;
      3'd2:    c = 8'h4E;
      3'd3:    c = 8'h44;
      3'd4:    c = CH_NEWLINE;
      default: c = CH_NEWLINE;
    endcase
    return c;
  endfunction

endpackage

FILE: hw/rtl/lled_step.sv
// Per-character decision logic: next line state and the result for one beat.
module lled_step #(
  parameter int DEPTH_BITS = 8
) (
  input  logic [7:0]              ch,
  input  logic                    end_of_input,
  input  lled_pkg::lled_cfg_t     cfg,
  input  lled_pkg::lled_flags_t   flags,
  input  logic [DEPTH_BITS-1:0]   paren_depth,
  input  logic [DEPTH_BITS-1:0]   bracket_depth,
  input  logic [DEPTH_BITS-1:0]   brace_depth,
  output lled_pkg::lled_flags_t   flags_next,
  output logic [DEPTH_BITS-1:0]   paren_next,
  output logic [DEPTH_BITS-1:0]   bracket_next,
  output logic [DEPTH_BITS-1:0]   brace_next,
  output lled_pkg::lled_result_t  res
);

  localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = '1;

  logic              keep;
  logic              esc;
  logic              run_body;
  logic              depths_zero;
  logic [2:0]        pos_eff;
  lled_pkg::reason_t reason;

  assign depths_zero = (paren_depth == '0) && (bracket_depth == '0) && (brace_depth == '0);

  always_comb begin
    flags_next   = flags;
    paren_next   = paren_depth;
    bracket_next = bracket_depth;
    brace_next   = brace_depth;
    keep         = 1'b0;
    esc          = 1'b0;
    run_body     = 1'b0;
    reason       = lled_pkg::REASON_NONE;
    pos_eff      = 3'd0;

    // Pick the rule that applies to this character.
    if (end_of_input) begin
      reason = lled_pkg::REASON_EOI;
    end else if (flags.tilde_skipping) begin
      if (ch != lled_pkg::CH_SPACE && ch != lled_pkg::CH_TAB) begin
        keep = 1'b1;
        flags_next.tilde_skipping = (ch == lled_pkg::CH_TILDE);
      end
    end else if (flags.escape_pending) begin
      flags_next.escape_pending = 1'b0;
      flags_next.escape_seen    = 1'b1;
      keep     = 1'b1;
      esc      = 1'b1;
      run_body = 1'b1;
    end else if (ch == lled_pkg::CH_NEWLINE && !flags.bar_quoted && depths_zero) begin
      reason = lled_pkg::REASON_NEWLINE;
    end else if (ch == lled_pkg::CH_BSLASH) begin
      flags_next.escape_pending = 1'b1;
    end else begin
      keep     = 1'b1;
      run_body = 1'b1;
    end

    // run_body characters feed the END matcher, then quoting and depth rules.
    if (run_body) begin
      if (cfg.end_check_enable) begin
        pos_eff = (flags.end_match_pos < lled_pkg::END_LEN) ? flags.end_match_pos : 3'd0;
        if ((ch & lled_pkg::FOLD_MASK) == lled_pkg::end_char(pos_eff)) begin
          if (pos_eff == lled_pkg::END_LAST) begin
            reason = lled_pkg::REASON_END;
          end else begin
            flags_next.end_match_pos = pos_eff + 3'd1;
          end
        end else begin
          flags_next.end_match_pos = 3'd0;
        end
      end
      if (reason == lled_pkg::REASON_NONE && !esc) begin
        if (ch == lled_pkg::CH_BAR) begin
          flags_next.bar_quoted = !flags.bar_quoted;
        end else if (cfg.continuation_enable && !flags.bar_quoted) begin
          if (ch == lled_pkg::CH_LPAREN) begin
            if (paren_depth != DEPTH_MAX) paren_next = paren_depth + 1'b1;
          end else if (paren_depth != '0 && ch == lled_pkg::CH_RPAREN) begin
            paren_next = paren_depth - 1'b1;
          end else if (ch == lled_pkg::CH_LBRACK) begin
            if (bracket_depth != DEPTH_MAX) bracket_next = bracket_depth + 1'b1;
          end else if (bracket_depth != '0 && ch == lled_pkg::CH_RBRACK) begin
            bracket_next = bracket_depth - 1'b1;
          end else if (ch == lled_pkg::CH_LBRACE) begin
            if (brace_depth != DEPTH_MAX) brace_next = brace_depth + 1'b1;
          end else if (brace_depth != '0 && ch == lled_pkg::CH_RBRACE) begin
            brace_next = brace_depth - 1'b1;
          end
        end
        if (!flags.bar_quoted && ch == lled_pkg::CH_TILDE) begin
          flags_next.tilde_skipping = 1'b1;
        end
      end
    end

    // Build the result; escape history is reported before a line end clears it.
    res.keep_valid      = keep;
    res.kept_char       = keep ? ch : 8'h00;
    res.escaped         = esc;
    res.line_done       = (reason != lled_pkg::REASON_NONE);
    res.end_reason      = reason;
    res.line_had_escape = flags_next.escape_seen;

    // A line end starts the next line from a clean state.
    if (reason != lled_pkg::REASON_NONE) begin
      flags_next   = '0;
      paren_next   = '0;
      bracket_next = '0;
      brace_next   = '0;
    end
  end

endmodule

FILE: hw/rtl/lled_out_reg.sv
// Result register on the master side; holds a beat while the sink stalls.
module lled_out_reg (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  lled_pkg::lled_result_t res,
  output logic                   space,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [7:0]             m_tdata,  // kept_char
  output logic [4:0]             m_tuser,  // keep_valid, escaped, end_reason[1:0], line_had_escape
  output logic                   m_tlast   // line_done
);

  // Room for a new result when empty or when the held beat leaves now.
  assign space = !m_tvalid || m_tready;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (space) begin
      m_tvalid <= load;
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    if (load && space) begin
      m_tdata <= res.kept_char;
      m_tuser <= {res.line_had_escape, res.end_reason, res.escaped, res.keep_valid};
      m_tlast <= res.line_done;
    end
  end

endmodule

FILE: hw/rtl/logical_line_end_detector.sv
// Logical line end detector.
// Characters arrive on the slave stream: s_tdata carries the byte and s_tlast
// marks end of input, in which case the byte is ignored. Each accepted beat
// produces exactly one result beat on the master stream: m_tdata is the kept
// character (zero when nothing is kept), m_tuser carries keep_valid,
// escaped, end_reason and line_had_escape, and m_tlast flags the line end.
// The cfg channel writes continuation_enable (index 0) and end_check_enable
// (index 1) from cfg_data; other indexes are ignored. cfg_ready is always high.
// An accepted character sits in the input register; its result is computed
// from it and captured in the result register once that register has room.
// Throughput is one character per cycle while the sink does not stall, set by
// the combinational update of the line state between the two registers.
// When the sink stalls, the result register holds its beat and the input
// register keeps one more; s_tready drops only when both are full.
// Reset clears the line state, empties both registers and sets both
// configuration bits to one.
`include "assert_macros.svh"

module logical_line_end_detector #(
  parameter int DEPTH_BITS = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // ch
  input  logic       s_tlast,   // end_of_input
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // kept_char
  output logic [4:0] m_tuser,   // keep_valid, escaped, end_reason[1:0], line_had_escape
  output logic       m_tlast,   // line_done
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_index,
  input  logic       cfg_data
);

  lled_pkg::lled_cfg_t    cfg;
  lled_pkg::lled_flags_t  flags;
  lled_pkg::lled_flags_t  flags_next;
  lled_pkg::lled_result_t res;

  logic [DEPTH_BITS-1:0] paren_depth;
  logic [DEPTH_BITS-1:0] bracket_depth;
  logic [DEPTH_BITS-1:0] brace_depth;
  logic [DEPTH_BITS-1:0] paren_next;
  logic [DEPTH_BITS-1:0] bracket_next;
  logic [DEPTH_BITS-1:0] brace_next;

  logic       in_valid;
  logic [7:0] in_ch;
  logic       in_eoi;
  logic       out_space;
  logic       step_go;

  // Configuration writes.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.continuation_enable <= 1'b1;
      cfg.end_check_enable    <= 1'b1;
    end else if (cfg_valid) begin
      if (cfg_index == lled_pkg::CFG_CONTINUATION) cfg.continuation_enable <= cfg_data;
      if (cfg_index == lled_pkg::CFG_END_CHECK)    cfg.end_check_enable    <= cfg_data;
    end
  end

  // Input register; a character is processed when the result register has room.
  assign step_go  = in_valid && out_space;
  assign s_tready = !in_valid || out_space;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_ch  <= s_tdata;
      in_eoi <= s_tlast;
    end
  end

  // Decision logic.
  lled_step #(
    .DEPTH_BITS(DEPTH_BITS)
  ) u_step (
    .ch            (in_ch),
    .end_of_input  (in_eoi),
    .cfg           (cfg),
    .flags         (flags),
    .paren_depth   (paren_depth),
    .bracket_depth (bracket_depth),
    .brace_depth   (brace_depth),
    .flags_next    (flags_next),
    .paren_next    (paren_next),
    .bracket_next  (bracket_next),
    .brace_next    (brace_next),
    .res           (res)
  );

  // Line state.
  always_ff @(posedge clk) begin
    if (rst) begin
      flags         <= '0;
      paren_depth   <= '0;
      bracket_depth <= '0;
      brace_depth   <= '0;
    end else if (step_go) begin
      flags         <= flags_next;
      paren_depth   <= paren_next;
      bracket_depth <= bracket_next;
      brace_depth   <= brace_next;
    end
  end

  // Result register.
  lled_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (in_valid),
    .res      (res),
    .space    (out_space),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // Checks on the block's own logic.
  `ASSERT_SAME(a_last_matches_reason, clk, rst, m_tvalid, (m_tlast == (m_tuser[3:2] != lled_pkg::REASON_NONE)), "line end flag disagrees with end reason")
  `ASSERT_SAME(a_unkept_is_zero, clk, rst, m_tvalid && !m_tuser[0], (m_tdata == 8'h00), "character reported without being kept")
  `ASSERT_SAME(a_escape_kept, clk, rst, m_tvalid && m_tuser[1], (m_tuser[0] && m_tuser[4]), "escaped beat not kept or not recorded")
  `ASSERT_NEXT(a_clear_after_end, clk, rst, step_go && res.line_done, (flags == '0 && paren_depth == '0 && bracket_depth == '0 && brace_depth == '0), "line state not cleared after a line end")
  `ASSERT_ALWAYS(a_match_pos_range, clk, rst, (flags.end_match_pos <= lled_pkg::END_LAST), "END matcher position out of range")

endmodule

FILE: tb/testbench.sv
module testbench;
  import lled_pkg::*;

  // A narrow depth counter lets random bracket runs reach saturation often.
  localparam int DEPTH_W = 3;
  localparam int RAND_ITEMS = 550;
  localparam int CHUNKS = 6;
  localparam int DRAIN_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int DIR_ROWS = 25;

  // One row of the directed table; use_table picks the typed-in result.
  typedef struct packed {
    logic [7:0]   ch;
    logic         eoi;
    logic         use_table;
    lled_result_t res;
  } dir_row_t;

  localparam lled_result_t NO_RESULT = '0;

  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    '{8'h00,      1'b0, 1'b1, '{1'b1, 8'h00, 1'b0, 1'b0, REASON_NONE, 1'b0}},
    '{CH_NEWLINE, 1'b0, 1'b1, '{1'b0, 8'h00, 1'b0, 1'b1, REASON_NEWLINE, 1'b0}},
    '{8'hFF,      1'b0, 1'b1, '{1'b1, 8'hFF, 1'b0, 1'b0, REASON_NONE, 1'b0}},
    '{CH_BSLASH,  1'b0, 1'b0, NO_RESULT},
    '{CH_LPAREN,  1'b0, 1'b0, NO_RESULT},
    '{CH_NEWLINE, 1'b0, 1'b0, NO_RESULT},
    '{CH_RBRACK,  1'b0, 1'b0, NO_RESULT},
    '{CH_LPAREN,  1'b0, 1'b0, NO_RESULT},
    '{CH_NEWLINE, 1'b0, 1'b0, NO_RESULT},
    '{CH_RPAREN,  1'b0, 1'b0, NO_RESULT},
    '{CH_BAR,     1'b0, 1'b0, NO_RESULT},
    '{CH_NEWLINE, 1'b0, 1'b0, NO_RESULT},
    '{8'h65,      1'b0, 1'b0, NO_RESULT},
    '{8'h6E,      1'b0, 1'b0, NO_RESULT},
    '{8'h44,      1'b0, 1'b0, NO_RESULT},
    '{CH_NEWLINE, 1'b0, 1'b1, '{1'b1, CH_NEWLINE, 1'b0, 1'b1, REASON_END, 1'b0}},
    '{CH_TILDE,   1'b0, 1'b0, NO_RESULT},
    '{CH_SPACE,   1'b0, 1'b0, NO_RESULT},
    '{CH_TAB,     1'b0, 1'b0, NO_RESULT},
    '{CH_TILDE,   1'b0, 1'b0, NO_RESULT},
    '{CH_NEWLINE, 1'b0, 1'b0, NO_RESULT},
    '{CH_BSLASH,  1'b0, 1'b0, NO_RESULT},
    '{8'hA5,      1'b1, 1'b1, '{1'b0, 8'h00, 1'b0, 1'b1, REASON_EOI, 1'b0}},
    '{CH_LBRACE,  1'b0, 1'b0, NO_RESULT},
    '{8'h5A,      1'b1, 1'b1, '{1'b0, 8'h00, 1'b0, 1'b1, REASON_EOI, 1'b0}}
  };

  // Register settings per random chunk: bit 1 continuation, bit 0 END check.
  localparam logic [1:0] CHUNK_CFG [CHUNKS] = '{2'b11, 2'b00, 2'b10, 2'b01, 2'b11, 2'b01};

  localparam logic [7:0] END_PATTERN [5] = '{CH_NEWLINE, 8'h45, 8'h4E, 8'h44, CH_NEWLINE};
  localparam logic [7:0] OPENERS [3] = '{CH_LPAREN, CH_LBRACK, CH_LBRACE};
  localparam logic [7:0] CLOSERS [3] = '{CH_RPAREN, CH_RBRACK, CH_RBRACE};

  logic       clk;
  logic       rst;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;   // ch
  logic       s_tlast;   // end_of_input
  logic       m_tvalid;
  logic       m_tready;
  logic [7:0] m_tdata;   // kept_char
  logic [4:0] m_tuser;   // keep_valid, escaped, end_reason[1:0], line_had_escape
  logic       m_tlast;   // line_done
  logic       cfg_valid;
  logic       cfg_ready;
  logic [7:0] cfg_index;
  logic       cfg_data;

  // Scanner state mirrored by the predictor.
  logic               cont_en;
  logic               endchk_en;
  logic               bar_q;
  logic [DEPTH_W-1:0] paren_d;
  logic [DEPTH_W-1:0] brack_d;
  logic [DEPTH_W-1:0] brace_d;
  logic               esc_pend;
  logic               tilde_skip;
  logic [2:0]         match_pos;
  logic               esc_seen;

  lled_result_t expected_lines [$];
  int           send_idle;
  int           recv_idle;
  int           fail_count;
  int           beats_sent;
  int unsigned  cycle_count;

  logical_line_end_detector #(.DEPTH_BITS(DEPTH_W)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog on the whole run.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Every line end starts the next line from a clean state.
  task automatic clear_line();
    bar_q = 1'b0;
    paren_d = '0;
    brack_d = '0;
    brace_d = '0;
    esc_pend = 1'b0;
    tilde_skip = 1'b0;
    match_pos = 3'd0;
    esc_seen = 1'b0;
  endtask

  // A character kept through the normal rules: END matcher, quoting, depths, tilde.
  task automatic feed_kept(input logic [7:0] c, input logic esc, output reason_t why);
    logic [2:0] pos;
    why = REASON_NONE;
    if (endchk_en) begin
      pos = (match_pos < END_LEN) ? match_pos : 3'd0;
      if ((c & FOLD_MASK) == END_PATTERN[pos]) begin
        if (pos == END_LAST) why = REASON_END;
        else match_pos = pos + 3'd1;
      end else begin
        match_pos = 3'd0;
      end
    end
    if (why == REASON_NONE && !esc) begin
      if (c == CH_BAR) begin
        bar_q = ~bar_q;
      end else if (cont_en && !bar_q) begin
        if (c == CH_LPAREN) begin
          if (paren_d != {DEPTH_W{1'b1}}) paren_d = paren_d + 1'b1;
        end else if (paren_d != 0 && c == CH_RPAREN) begin
          paren_d = paren_d - 1'b1;
        end else if (c == CH_LBRACK) begin
          if (brack_d != {DEPTH_W{1'b1}}) brack_d = brack_d + 1'b1;
        end else if (brack_d != 0 && c == CH_RBRACK) begin
          brack_d = brack_d - 1'b1;
        end else if (c == CH_LBRACE) begin
          if (brace_d != {DEPTH_W{1'b1}}) brace_d = brace_d + 1'b1;
        end else if (brace_d != 0 && c == CH_RBRACE) begin
          brace_d = brace_d - 1'b1;
        end
      end
      if (!bar_q && c == CH_TILDE) tilde_skip = 1'b1;
    end
  endtask

  // Predicts the result beat of one accepted character and advances the state.
  task automatic scan_char(input logic [7:0] c, input logic eoi, output lled_result_t r);
    reason_t why;
    why = REASON_NONE;
    r = '0;
    if (eoi) begin
      why = REASON_EOI;
    end else if (tilde_skip) begin
      if (c != CH_SPACE && c != CH_TAB) begin
        r.keep_valid = 1'b1;
        tilde_skip = (c == CH_TILDE);
      end
    end else if (esc_pend) begin
      esc_pend = 1'b0;
      esc_seen = 1'b1;
      r.keep_valid = 1'b1;
      r.escaped = 1'b1;
      feed_kept(c, 1'b1, why);
    end else if (c == CH_NEWLINE && !bar_q && paren_d == 0 && brack_d == 0 &&
                 brace_d == 0) begin
      why = REASON_NEWLINE;
    end else if (c == CH_BSLASH) begin
      esc_pend = 1'b1;
    end else begin
      r.keep_valid = 1'b1;
      feed_kept(c, 1'b0, why);
    end
    r.kept_char = r.keep_valid ? c : 8'h00;
    r.line_done = (why != REASON_NONE);
    r.end_reason = why;
    r.line_had_escape = esc_seen;
    if (why != REASON_NONE) clear_line();
  endtask

  // Sends one character beat, with random idle cycles ahead of it.
  task automatic push_char(input logic [7:0] c, input logic eoi, input logic use_table,
                           input lled_result_t table_res);
    lled_result_t r;
    bit           ok;
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= c;
    s_tlast <= eoi;
    do begin
      @(negedge clk);
      ok = s_tready;
      @(posedge clk);
    end while (!ok);
    scan_char(c, eoi, r);
    expected_lines.push_back(use_table ? table_res : r);
    beats_sent++;
  endtask

  task automatic put_char(input logic [7:0] c);
    push_char(c, 1'b0, 1'b0, NO_RESULT);
  endtask

  // One configuration write; cfg_valid is lowered by the caller.
  task automatic write_cfg(input logic [7:0] idx, input logic val);
    bit ok;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do begin
      @(negedge clk);
      ok = cfg_ready;
      @(posedge clk);
    end while (!ok);
    if (idx == CFG_CONTINUATION) cont_en = val;
    else if (idx == CFG_END_CHECK) endchk_en = val;
  endtask

  // Stops sending and waits until every result beat has come back.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (expected_lines.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Character mix for random lines, weighted toward the special characters.
  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(99);
    if (r < 30) return 8'($urandom_range(8'h41, 8'h5A)) | ($urandom_range(1) ? 8'h20 : 8'h00);
    if (r < 40) return OPENERS[$urandom_range(2)];
    if (r < 50) return CLOSERS[$urandom_range(2)];
    if (r < 56) return CH_BAR;
    if (r < 62) return CH_BSLASH;
    if (r < 67) return CH_TILDE;
    if (r < 73) return CH_SPACE;
    if (r < 76) return CH_TAB;
    if (r < 80) return CH_NEWLINE;
    return 8'($urandom_range(255));
  endfunction

  // Sets bits that the fold mask drops, so aliases of the END characters match too.
  function automatic logic [7:0] folded_alias(input logic [7:0] c);
    logic [7:0] v;
    v = c;
    if ($urandom_range(3) == 0) v = v | 8'h80;
    if ($urandom_range(3) == 0) v = v | 8'h20;
    return v;
  endfunction

  // One random line of a randomly chosen kind.
  task automatic random_line();
    int kind;
    int broken_at;
    int idx;
    kind = $urandom_range(99);
    if (kind < 45) begin
      // Ordinary text with brackets, quotes, escapes and tildes.
      repeat ($urandom_range(1, 14)) put_char(pick_char());
      if ($urandom_range(99) < 15) push_char(8'($urandom_range(255)), 1'b1, 1'b0, NO_RESULT);
      else put_char(CH_NEWLINE);
    end else if (kind < 65) begin
      // END sequence, sometimes held open by a bracket, a quote or an escape, sometimes broken.
      case ($urandom_range(3))
        0: put_char(CH_LPAREN);
        1: put_char(CH_BAR);
        2: put_char(CH_BSLASH);
        default: ;
      endcase
      broken_at = $urandom_range(24);
      for (int k = 0; k < 5; k++) begin
        if (k == broken_at) put_char(pick_char());
        else put_char(folded_alias(END_PATTERN[k]));
      end
    end else if (kind < 75) begin
      // Bracket run that often reaches saturation, then a random number of closers.
      idx = $urandom_range(2);
      repeat ($urandom_range(6, 10)) put_char(OPENERS[idx]);
      repeat ($urandom_range(0, 9)) put_char(CLOSERS[idx]);
      put_char(CH_NEWLINE);
    end else if (kind < 85) begin
      // Tilde followed by blanks and a raw character.
      put_char(CH_TILDE);
      repeat ($urandom_range(0, 3)) put_char($urandom_range(1) ? CH_SPACE : CH_TAB);
      put_char(pick_char());
    end else begin
      // Noise bytes, often closed by end of input.
      repeat ($urandom_range(1, 5)) put_char(8'($urandom_range(255)));
      if ($urandom_range(2) == 0) push_char(8'($urandom_range(255)), 1'b1, 1'b0, NO_RESULT);
    end
  endtask

  // Result sink: random stalls, each accepted beat checked against the oldest expectation.
  initial begin
    lled_result_t want;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      m_tready <= ($urandom_range(99) >= recv_idle);
      @(negedge clk);
      if (!rst && m_tvalid && m_tready) begin
        if (expected_lines.size() == 0) begin
          $error("result beat with nothing expected");
          fail_count++;
        end else begin
          want = expected_lines.pop_front();
          if (m_tuser[0] !== want.keep_valid) begin
            $error("keep_valid: expected %0d, got %0d", want.keep_valid, m_tuser[0]);
            fail_count++;
          end
          if (m_tdata !== want.kept_char) begin
            $error("kept_char: expected %0h, got %0h", want.kept_char, m_tdata);
            fail_count++;
          end
          if (m_tuser[1] !== want.escaped) begin
            $error("escaped: expected %0d, got %0d", want.escaped, m_tuser[1]);
            fail_count++;
          end
          if (m_tlast !== want.line_done) begin
            $error("line_done: expected %0d, got %0d", want.line_done, m_tlast);
            fail_count++;
          end
          if (m_tuser[3:2] !== want.end_reason) begin
            $error("end_reason: expected %0d, got %0d", want.end_reason, m_tuser[3:2]);
            fail_count++;
          end
          if (m_tuser[4] !== want.line_had_escape) begin
            $error("line_had_escape: expected %0d, got %0d", want.line_had_escape,
                   m_tuser[4]);
            fail_count++;
          end
        end
      end
    end
  end

  // Main sequence: reset, directed table, then random chunks under changing settings.
  initial begin
    int chunk_base;
    fail_count = 0;
    beats_sent = 0;
    send_idle = 28;
    recv_idle = 66;
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= 8'h00;
    s_tlast <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= 8'h00;
    cfg_data <= 1'b0;
    cont_en = 1'b1;
    endchk_en = 1'b1;
    clear_line();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table at reset settings.
    for (int i = 0; i < DIR_ROWS; i++) begin
      push_char(DIR_TABLE[i].ch, DIR_TABLE[i].eoi, DIR_TABLE[i].use_table,
                DIR_TABLE[i].res);
    end
    settle();

    chunk_base = beats_sent;
    for (int chunk = 0; chunk < CHUNKS; chunk++) begin
      // Idle pattern: sender light and sink heavy, then swapped, then none.
      if (chunk < 2) begin
        send_idle = 28;
        recv_idle = 66;
      end else if (chunk < 4) begin
        send_idle = 66;
        recv_idle = 28;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end

      // New settings while idle; an index past the register list is ignored.
      write_cfg(CFG_CONTINUATION, CHUNK_CFG[chunk][1]);
      write_cfg(CFG_END_CHECK, CHUNK_CFG[chunk][0]);
      write_cfg(8'($urandom_range(255, 2)), 1'($urandom_range(1)));
      cfg_valid <= 1'b0;

      while (beats_sent < chunk_base + (chunk + 1) * RAND_ITEMS / CHUNKS) random_line();
      settle();
    end

    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
